// ===== design/tsf_pkg.sv =====
// Package for the trapezoidal shaping filter: register widths, register
// indexes, tap numbering and the stage control struct.
// No dependencies.
`default_nettype none

package tsf_pkg;

  localparam int RISE_W     = 10;
  localparam int TOP_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = 12;  // rise plus top delay
  localparam int SHAPED_W   = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RISE_W-1:0] RISE_RESET = RISE_W'(16);
  localparam logic [TOP_W-1:0]  TOP_RESET  = TOP_W'(32);
  localparam logic [GAIN_W-1:0] GAIN_RESET = '0;

  localparam int NUM_TAPS = 3;
  localparam int TAP_K    = 0;
  localparam int TAP_L    = 1;
  localparam int TAP_KL   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_LENGTH = 2'd0,
    REG_TOP_DELAY   = 2'd1,
    REG_POLE_GAIN   = 2'd2
  } cfg_reg_t;

  // Per-tap selection for the sample that sits in the first stage.
  typedef struct packed {
    logic                valid;
    logic                first;
    logic [NUM_TAPS-1:0] zero;  // delay of zero: the tap is the current sample
    logic [NUM_TAPS-1:0] hit;   // tap lies inside the trace and the delay line
  } tap_ctl_t;

endpackage

`default_nettype wire

// ===== design/tsf_ram.sv =====
// Simple dual-port delay line memory: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tsf_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 14
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tsf_taps.sv =====
// Delay line front end: write pointer, trace length count, tap addresses
// and three memory copies, one per tap. Uses tsf_pkg and tsf_ram.
`default_nettype none

module tsf_taps import tsf_pkg::*; #(
  parameter int MAX_DELAY   = 2048,
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   adv,
  input  wire logic                                   acc,
  input  wire logic [SAMPLE_BITS-1:0]                 sample,
  input  wire logic                                   first_sample,
  input  wire logic [RISE_W-1:0]                      rise_length,
  input  wire logic [TOP_W-1:0]                       top_delay,
  output logic      [SAMPLE_BITS-1:0]                 cur,
  output logic      [NUM_TAPS-1:0][SAMPLE_BITS-1:0]   tap_data,
  output tap_ctl_t                                    ctl
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = (AW + 1 > SUM_W) ? AW + 1 : SUM_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_C  = AW'(MAX_DELAY - 1);

  logic [AW-1:0] wp;
  logic [AW-1:0] filled;
  logic [AW-1:0] filled_eff;
  logic [CW-1:0] dly [NUM_TAPS];
  logic [AW-1:0] raddr [NUM_TAPS];
  logic [NUM_TAPS-1:0] zero_next;
  logic [NUM_TAPS-1:0] hit_next;

  assign filled_eff = first_sample ? '0 : filled;

  always_comb begin
    logic [CW-1:0] wp_ext;
    logic [CW-1:0] a;
    wp_ext = CW'(wp);
    dly[TAP_K]  = CW'(rise_length);
    dly[TAP_L]  = CW'(top_delay);
    dly[TAP_KL] = CW'(rise_length) + CW'(top_delay);
    for (int i = 0; i < NUM_TAPS; i++) begin
      // Ring address of the sample that lies dly[i] places back.
      if (wp_ext >= dly[i]) begin
        a = wp_ext - dly[i];
      end else begin
        a = wp_ext + DEPTH_C - dly[i];
      end
      raddr[i]     = a[AW-1:0];
      zero_next[i] = (dly[i] == '0);
      hit_next[i]  = (dly[i] != '0) && (dly[i] < DEPTH_C) && (dly[i] <= CW'(filled_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      filled <= '0;
    end else if (acc) begin
      wp     <= (wp == LAST_C) ? '0 : wp + AW'(1);
      filled <= (filled_eff < LAST_C) ? filled_eff + AW'(1) : filled_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl.valid <= acc;
    end
    if (adv) begin
      cur       <= sample;
      ctl.first <= first_sample;
      ctl.zero  <= zero_next;
      ctl.hit   <= hit_next;
    end
  end

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
    tsf_ram #(
      .DEPTH(MAX_DELAY),
      .WIDTH(SAMPLE_BITS)
    ) u_ram (
      .clk  (clk),
      .we   (acc),
      .waddr(wp),
      .wdata(sample),
      .re   (adv),
      .raddr(raddr[g]),
      .rdata(tap_data[g])
    );
  end

endmodule

`default_nettype wire

// ===== design/tsf_accum.sv =====
// Difference, accumulator and pole-zero stages of the shaper, ending in the
// output register. Uses tsf_pkg.
`default_nettype none

module tsf_accum import tsf_pkg::*; #(
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire logic [SAMPLE_BITS-1:0]               cur,
  input  wire logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] tap_data,
  input  tap_ctl_t                                  ctl,
  input  wire logic [GAIN_W-1:0]                    pole_gain,
  output logic                                      out_valid,
  output logic signed [SHAPED_W-1:0]                shaped
);

  localparam int DW = SAMPLE_BITS + 2;
  localparam int PW = GAIN_W + 1 + DW;

  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] tv;
  logic signed [DW-1:0] d_next;

  logic                  valid2;
  logic                  first2;
  logic signed [DW-1:0]  d2;

  logic                  valid3;
  logic                  first3;
  logic signed [PW-1:0]  prod3;
  logic signed [PW-1:0]  prod_next;

  logic [SHAPED_W-1:0]   p;
  logic [SHAPED_W-1:0]   p_next;
  logic [SHAPED_W-1:0]   s_next;

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (ctl.zero[i]) begin
        tv[i] = cur;
      end else if (ctl.hit[i]) begin
        tv[i] = tap_data[i];
      end else begin
        tv[i] = '0;
      end
    end
    d_next = $signed({2'b00, cur}) - $signed({2'b00, tv[TAP_K]})
           - $signed({2'b00, tv[TAP_L]}) + $signed({2'b00, tv[TAP_KL]});
  end

  assign prod_next = $signed({{(PW-GAIN_W){1'b0}}, pole_gain})
                   * $signed({{(PW-DW){d2[DW-1]}}, d2});
  assign p_next = (first2 ? '0 : p) + {{(SHAPED_W-DW){d2[DW-1]}}, d2};
  assign s_next = (first3 ? '0 : shaped) + p + {{(SHAPED_W-PW){prod3[PW-1]}}, prod3};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      out_valid <= 1'b0;
      p         <= '0;
      shaped    <= '0;
    end else if (adv) begin
      valid2    <= ctl.valid;
      valid3    <= valid2;
      out_valid <= valid3;
      if (valid2) begin
        p <= p_next;
      end
      if (valid3) begin
        shaped <= s_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first2 <= ctl.first;
      d2     <= d_next;
      first3 <= first2;
      prod3  <= prod_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/trapezoidal_shaping_filter.sv =====
// Trapezoidal shaping filter, one shaped value per ADC sample.
// Pipeline: tap stage (delay line read), difference d2, product prod3 and sum p, output shaped.
// Throughput: one sample per cycle while no result waits, set by the p and s accumulator
// updates; the pipeline stalls as a whole while a result waits. Synchronous reset clears
// pipeline valids, write pointer, trace count, accumulators and restores register defaults;
// the delay line is not cleared. Depends on tsf_pkg, tsf_taps and tsf_accum.
`default_nettype none

module trapezoidal_shaping_filter import tsf_pkg::*; #(
  parameter int MAX_DELAY   = 2048,
  parameter int SAMPLE_BITS = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [SAMPLE_BITS-1:0]     sample,
  input  wire logic                       first_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SHAPED_W-1:0]      shaped
);

  logic [RISE_W-1:0] rise_length;
  logic [TOP_W-1:0]  top_delay;
  logic [GAIN_W-1:0] pole_gain;

  logic adv;
  logic acc;
  logic [SAMPLE_BITS-1:0]               cur;
  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] tap_data;
  tap_ctl_t                             ctl;

  // Every stage moves on unless a finished result is held back.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_length <= RISE_RESET;
      top_delay   <= TOP_RESET;
      pole_gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RISE_LENGTH: rise_length <= cfg_data[RISE_W-1:0];
        REG_TOP_DELAY:   top_delay   <= cfg_data[TOP_W-1:0];
        REG_POLE_GAIN:   pole_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  tsf_taps #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_taps (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .acc         (acc),
    .sample      (sample),
    .first_sample(first_sample),
    .rise_length (rise_length),
    .top_delay   (top_delay),
    .cur         (cur),
    .tap_data    (tap_data),
    .ctl         (ctl)
  );

  tsf_accum #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cur      (cur),
    .tap_data (tap_data),
    .ctl      (ctl),
    .pole_gain(pole_gain),
    .out_valid(out_valid),
    .shaped   (shaped)
  );

endmodule

`default_nettype wire

// ===== design/tsf_checker.sv =====
// Port-level checks for the trapezoidal shaping filter, bound to the top level.
// Uses tsf_pkg.
`default_nettype none

module tsf_checker import tsf_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SHAPED_W-1:0] shaped
);

  // A result that is held back stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shaped))
    else $error("held result changed before its transfer");

  // The input side is blocked only by a result that waits.
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // A stalled input is not taken while the output is blocked.
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the result is stalled");

  // No result is shown in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind trapezoidal_shaping_filter tsf_checker u_tsf_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for trapezoidal_shaping_filter: directed rows, then random
// traces under random register settings, with bursty input and a stalling receiver.
// Depends on tsf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb;
  import tsf_pkg::*;

  localparam int LINE_DEPTH = 2048;
  localparam int SAMPLE_W   = 14;
  localparam int LATENCY    = 4;

  typedef struct {
    logic                is_cfg;
    cfg_reg_t            sel;
    logic [15:0]         data;
    logic [SAMPLE_W-1:0] v;
    logic                first;
    logic                known;
    logic [63:0]         value;
  } step_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    sample;
  logic                   first_sample;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [63:0]     shaped;

  // Filter state as the testbench sees it.
  logic [SAMPLE_W-1:0]    history [LINE_DEPTH];
  int unsigned            wr_ptr;
  int unsigned            trace_len;
  logic [63:0]            p_sum;
  logic [63:0]            s_sum;
  logic [RISE_W-1:0]      rise_k;
  logic [TOP_W-1:0]       top_l;
  logic [GAIN_W-1:0]      gain_m;

  logic [63:0]            shaped_q [$];
  logic [63:0]            want;
  step_t                  steps [$];
  int                     errors;
  int                     burst_left;
  int                     items_sent;
  int                     ready_mode = 0;
  int                     mode_left  = 0;

  trapezoidal_shaping_filter #(
    .MAX_DELAY  (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .first_sample(first_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shaped      (shaped)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // A tap before the start of the trace or past the end of the delay line reads zero.
  function automatic logic [SAMPLE_W-1:0] tap_at(int unsigned dly, logic [SAMPLE_W-1:0] v);
    if (dly == 0) return v;
    if (dly >= LINE_DEPTH || dly > trace_len) return '0;
    return history[(wr_ptr + LINE_DEPTH - dly) % LINE_DEPTH];
  endfunction

  function automatic logic [63:0] shape_sample(logic [SAMPLE_W-1:0] v, logic first);
    logic [63:0] d;
    if (first) begin
      trace_len = 0;
      p_sum     = '0;
      s_sum     = '0;
    end
    d = 64'(v) - 64'(tap_at(int'(rise_k), v)) - 64'(tap_at(int'(top_l), v))
        + 64'(tap_at(int'(rise_k) + int'(top_l), v));
    p_sum = p_sum + d;
    s_sum = s_sum + p_sum + 64'(gain_m) * d;
    history[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
    if (trace_len < LINE_DEPTH - 1) trace_len++;
    return s_sum;
  endfunction

  function automatic step_t item_row(logic [SAMPLE_W-1:0] v, logic first);
    step_t r;
    r = '{is_cfg: 1'b0, sel: REG_RISE_LENGTH, data: '0, v: v, first: first,
          known: 1'b0, value: '0};
    return r;
  endfunction

  function automatic step_t known_row(logic [SAMPLE_W-1:0] v, logic first, logic [63:0] value);
    step_t r;
    r = item_row(v, first);
    r.known = 1'b1;
    r.value = value;
    return r;
  endfunction

  function automatic step_t cfg_row(cfg_reg_t sel, logic [15:0] data);
    step_t r;
    r = item_row('0, 1'b0);
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.data   = data;
    return r;
  endfunction

  function automatic void add_step(step_t r);
    steps.insert(steps.size(), r);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Receiver: switches between always ready, random ready and long stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (shaped_q.size() == 0) begin
        $error("shaped: expected nothing, actual %0d", shaped);
        errors++;
      end else begin
        want = shaped_q.pop_front();
        if (shaped !== want) begin
          $error("shaped: expected %0d, actual %0d", $signed(want), shaped);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic [SAMPLE_W-1:0] v, logic first, logic known,
                           logic [63:0] value);
    int          gap;
    logic [63:0] pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    sample       <= v;
    first_sample <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = shape_sample(v, first);
    shaped_q.insert(shaped_q.size(), known ? value : pred);
    burst_left--;
    items_sent++;
  endtask

  // Drain the pipeline before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    case (sel)
      REG_RISE_LENGTH: rise_k = data[RISE_W-1:0];
      REG_TOP_DELAY:   top_l  = data[TOP_W-1:0];
      default:         gain_m = data;
    endcase
  endtask

  task automatic random_config();
    logic [15:0] k_word;
    logic [15:0] l_word;
    logic [15:0] m_word;
    int          k;
    int          l;
    k_word = 16'($urandom);
    l_word = 16'($urandom);
    case ($urandom_range(0, 5))
      0: k = 0;
      1: k = 1023;
      2: k = $urandom_range(0, 1023);
      default: k = $urandom_range(1, 24);
    endcase
    case ($urandom_range(0, 6))
      0: l = $urandom_range(0, 1);
      1: l = 2047;
      2: l = 1024;
      3: l = $urandom_range(0, 2047);
      default: l = (k + $urandom_range(1, 40) > 2047) ? 2047 : k + $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 4))
      0: m_word = '0;
      1: m_word = '1;
      2: m_word = 16'($urandom);
      default: m_word = 16'($urandom_range(0, 300));
    endcase
    k_word[RISE_W-1:0] = RISE_W'(k);
    l_word[TOP_W-1:0]  = TOP_W'(l);
    settle();
    write_reg(REG_RISE_LENGTH, k_word);
    write_reg(REG_TOP_DELAY, l_word);
    write_reg(REG_POLE_GAIN, m_word);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int len;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_RISE_LENGTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    sample       = '0;
    first_sample = 1'b0;
    errors       = 0;
    burst_left   = 0;
    items_sent   = 0;
    wr_ptr       = 0;
    trace_len    = 0;
    p_sum        = '0;
    s_sum        = '0;
    rise_k       = RISE_RESET;
    top_l        = TOP_RESET;
    gain_m       = GAIN_RESET;

    // Samples before any first mark belong to a trace that began at reset.
    add_step(known_row('0, 1'b0, 64'd0));
    add_step(known_row('1, 1'b0, 64'd16383));
    add_step(known_row('1, 1'b1, 64'd16383));
    add_step(item_row('1, 1'b0));
    add_step(item_row('0, 1'b0));
    add_step(item_row(14'h2AAA, 1'b0));
    add_step(item_row(14'h1555, 1'b0));
    add_step(cfg_row(REG_POLE_GAIN, 16'hFFFF));
    add_step(known_row('1, 1'b1, 64'd1073676288));
    add_step(item_row('0, 1'b0));
    add_step(item_row('1, 1'b0));
    // Zero rise delay: that tap reads the current sample.
    add_step(cfg_row(REG_RISE_LENGTH, 16'd0));
    add_step(cfg_row(REG_TOP_DELAY, 16'd1));
    add_step(item_row(14'd100, 1'b1));
    add_step(item_row(14'd200, 1'b0));
    add_step(item_row(14'd300, 1'b0));
    // Second delay shorter than the first.
    add_step(cfg_row(REG_RISE_LENGTH, 16'd5));
    add_step(cfg_row(REG_TOP_DELAY, 16'd2));
    add_step(item_row('1, 1'b1));
    add_step(item_row(14'd9, 1'b0));
    add_step(item_row(14'h3000, 1'b0));
    add_step(item_row(14'h0FFF, 1'b0));
    // Largest delays: the combined tap falls off the end of the delay line.
    add_step(cfg_row(REG_RISE_LENGTH, 16'hFFFF));
    add_step(cfg_row(REG_TOP_DELAY, 16'hFFFF));
    add_step(cfg_row(REG_POLE_GAIN, 16'd0));
    add_step(item_row('1, 1'b1));
    add_step(item_row(14'd1, 1'b0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_reg(steps[i].sel, steps[i].data);
        cfg_we <= 1'b0;
      end else begin
        send_item(steps[i].v, steps[i].first, steps[i].known, steps[i].value);
      end
    end

    // One long trace whose taps reach far back into the delay line.
    settle();
    write_reg(REG_RISE_LENGTH, 16'($urandom_range(1, 20)));
    write_reg(REG_TOP_DELAY, 16'd1100);
    write_reg(REG_POLE_GAIN, 16'($urandom));
    cfg_we <= 1'b0;
    for (int j = 0; j < 1200; j++) send_item(rand_sample(), j == 0, 1'b0, '0);

    // Short traces under random settings; some continue across a register change
    // and a few carry a stray first mark.
    while (items_sent < 1900) begin
      random_config();
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 120);
        for (int j = 0; j < len; j++) begin
          send_item(rand_sample(),
                    (j == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 59) == 0,
                    1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (errors == 0 && shaped_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tsf_pkg.sv
design/tsf_ram.sv
design/tsf_taps.sv
design/tsf_accum.sv
design/trapezoidal_shaping_filter.sv
design/tsf_checker.sv
verif/tb.sv
